### rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// shared constants, types and the gradient function of the sobel block
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 8;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

  // control carried alongside a request in the window stage
  typedef struct packed {
    logic [ADDR_W-1:0] col;
    logic              has_result;
    logic              last;
  } s1_ctrl_t;

  // |(tr - tl) + 2*(mr - ml) + (br - bl)| saturated to 255
  function automatic logic [PIX_W-1:0] abs_grad(
    input logic [PIX_W-1:0] tr, input logic [PIX_W-1:0] tl,
    input logic [PIX_W-1:0] mr, input logic [PIX_W-1:0] ml,
    input logic [PIX_W-1:0] br, input logic [PIX_W-1:0] bl
  );
    logic signed [10:0] d_top;
    logic signed [10:0] d_mid;
    logic signed [10:0] d_bot;
    logic signed [10:0] sum;
    logic [10:0]        mag;
    d_top = $signed({3'b000, tr}) - $signed({3'b000, tl});
    d_mid = $signed({3'b000, mr}) - $signed({3'b000, ml});
    d_bot = $signed({3'b000, br}) - $signed({3'b000, bl});
    sum   = d_top + (d_mid <<< 1) + d_bot;
    mag   = sum[10] ? 11'(-sum) : 11'(sum);
    return (mag > 11'd255) ? {PIX_W{1'b1}} : mag[PIX_W-1:0];
  endfunction

endpackage

### rtl/sobel_line_buf.sv
// ----------------------------------------------------------------------------
// sobel_line_buf
// two line stores holding the previous two rows, registered read
// ----------------------------------------------------------------------------
module sobel_line_buf (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [sobel_pkg::ADDR_W-1:0]  rd_addr,
  input  logic                          wr_en,
  input  logic [sobel_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [sobel_pkg::PIX_W-1:0]   wr_a,
  input  logic [sobel_pkg::PIX_W-1:0]   wr_b,
  output logic [sobel_pkg::PIX_W-1:0]   rd_a,
  output logic [sobel_pkg::PIX_W-1:0]   rd_b
);

  logic [sobel_pkg::PIX_W-1:0] mem_a [sobel_pkg::MAX_WIDTH];
  logic [sobel_pkg::PIX_W-1:0] mem_b [sobel_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem_a[rd_addr];
      rd_b <= mem_b[rd_addr];
    end
  end

endmodule

### rtl/sobel_horizontal_gradient.sv
// ----------------------------------------------------------------------------
// sobel_horizontal_gradient
// absolute horizontal 3x3 sobel gradient over a raster pixel stream
// ----------------------------------------------------------------------------
// pixels enter on pixel / in_valid / in_stall in raster order, one request per
// clock at full rate while in_stall is low. each pixel at row >= 2 and column
// >= 2 yields one result on gradient / frame_last / out_valid / out_stall;
// other pixels yield none. frame_last marks the result of the last pixel of a
// frame. a pixel taken is held in the window stage while the line stores are
// read; the window update and gradient then go into the output register. the
// full rate is set by the single line store read and write per pixel.
// image_width and image_height are written through cfg_write / cfg_index /
// cfg_data, by the user only while idle (not enforced by the block); a write
// restarts the frame at row 0, column 0. reset (rst, synchronous) returns the
// registers to 640 x 480, clears the counters and the window; the line stores
// are not cleared and need no pass. when out_stall holds a result, the window
// stage still takes a pixel that yields no result; in_stall rises only once a
// held result blocks the stage.
// ----------------------------------------------------------------------------
module sobel_horizontal_gradient (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sobel_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sobel_pkg::PIX_W-1:0]       pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sobel_pkg::PIX_W-1:0]       gradient,
  output logic                              frame_last
);

  logic [sobel_pkg::WIDTH_W-1:0]  image_width;
  logic [sobel_pkg::HEIGHT_W-1:0] image_height;
  logic [sobel_pkg::WIDTH_W-1:0]  width_eff;
  logic [sobel_pkg::HEIGHT_W-1:0] height_eff;

  logic [sobel_pkg::ADDR_W-1:0]   column_count;
  logic [sobel_pkg::ADDR_W-1:0]   column_count_next;
  logic [sobel_pkg::HEIGHT_W-1:0] row_count;
  logic [sobel_pkg::HEIGHT_W-1:0] row_count_next;
  logic                           col_end;
  logic                           row_end;

  logic                           accept;
  logic                           s1_valid;
  sobel_pkg::s1_ctrl_t            s1_ctrl;
  sobel_pkg::s1_ctrl_t            s1_ctrl_next;
  logic [sobel_pkg::PIX_W-1:0]    s1_pixel;
  logic                           s1_go;
  logic                           out_free;

  logic [sobel_pkg::PIX_W-1:0]    above1;
  logic [sobel_pkg::PIX_W-1:0]    above2;

  logic [sobel_pkg::PIX_W-1:0]    win_top_c;
  logic [sobel_pkg::PIX_W-1:0]    win_top_r;
  logic [sobel_pkg::PIX_W-1:0]    win_mid_c;
  logic [sobel_pkg::PIX_W-1:0]    win_mid_r;
  logic [sobel_pkg::PIX_W-1:0]    win_bot_c;
  logic [sobel_pkg::PIX_W-1:0]    win_bot_r;
  logic [sobel_pkg::PIX_W-1:0]    grad_next;

  // effective frame size
  always_comb begin
    priority if (image_width < sobel_pkg::WIDTH_MIN) begin
      width_eff = sobel_pkg::WIDTH_MIN;
    end else if (image_width > sobel_pkg::WIDTH_MAX) begin
      width_eff = sobel_pkg::WIDTH_MAX;
    end else begin
      width_eff = image_width;
    end
    height_eff = (image_height < sobel_pkg::HEIGHT_MIN) ? sobel_pkg::HEIGHT_MIN
                                                         : image_height;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sobel_pkg::WIDTH_RESET;
      image_height <= sobel_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == sobel_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg_data[sobel_pkg::WIDTH_W-1:0];
      end
      if (cfg_index == sobel_pkg::REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data[sobel_pkg::HEIGHT_W-1:0];
      end
    end
  end

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (out_free || !s1_ctrl.has_result);
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;

  // position counters
  always_comb begin
    col_end = ({1'b0, column_count} + sobel_pkg::WIDTH_W'(1)) >= width_eff;
    row_end = ({1'b0, row_count} + 13'd1) >= {1'b0, height_eff};
    column_count_next = column_count + sobel_pkg::ADDR_W'(1);
    row_count_next    = row_count;
    if (col_end) begin
      column_count_next = '0;
      row_count_next    = row_end ? '0 : row_count + sobel_pkg::HEIGHT_W'(1);
    end
    s1_ctrl_next.col        = column_count;
    s1_ctrl_next.has_result = (row_count >= sobel_pkg::HEIGHT_W'(2)) &&
                              (column_count >= sobel_pkg::ADDR_W'(2));
    s1_ctrl_next.last       = row_end && col_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_write && (cfg_index == sobel_pkg::REG_IMAGE_WIDTH ||
                               cfg_index == sobel_pkg::REG_IMAGE_HEIGHT)) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // window stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl  <= s1_ctrl_next;
      s1_pixel <= pixel;
    end
  end

  sobel_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (column_count),
    .wr_en   (s1_go),
    .wr_addr (s1_ctrl.col),
    .wr_a    (s1_pixel),
    .wr_b    (above1),
    .rd_a    (above1),
    .rd_b    (above2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win_top_c <= '0;
      win_top_r <= '0;
      win_mid_c <= '0;
      win_mid_r <= '0;
      win_bot_c <= '0;
      win_bot_r <= '0;
    end else if (s1_go) begin
      win_top_c <= win_top_r;
      win_top_r <= above2;
      win_mid_c <= win_mid_r;
      win_mid_r <= above1;
      win_bot_c <= win_bot_r;
      win_bot_r <= s1_pixel;
    end
  end

  // new left column is the old center, new right column is the fresh one
  assign grad_next = sobel_pkg::abs_grad(above2, win_top_c, above1, win_mid_c,
                                         s1_pixel, win_bot_c);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && s1_ctrl.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && s1_ctrl.has_result) begin
      gradient   <= grad_next;
      frame_last <= s1_ctrl.last;
    end
  end

`ifndef SYNTH
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_count} < width_eff)
    else $error("column count beyond frame width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row_count < height_eff)
    else $error("row count beyond frame height");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && s1_ctrl_next.last && !cfg_write |=>
      column_count == '0 && row_count == '0)
    else $error("counters did not return to origin after last pixel");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_ctrl) && $stable(s1_pixel))
    else $error("window stage lost a held request");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for sobel_horizontal_gradient
// streams pixel frames of many sizes through the block with random idle and
// stall gaps on both sides. a software copy of the line stores, window and
// counters predicts each gradient and frame_last. results are checked in
// order against that prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PIXELS = 400;
  localparam int SHORT_RUN     = 40;

  localparam logic [sobel_pkg::CFG_IDX_W-1:0] REG_SPARE_A = sobel_pkg::CFG_IDX_W'(2);
  localparam logic [sobel_pkg::CFG_IDX_W-1:0] REG_SPARE_B = sobel_pkg::CFG_IDX_W'(3);

  typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_SMOOTH} fill_t;

  typedef struct packed {
    logic [sobel_pkg::PIX_W-1:0] gradient;
    logic                        frame_last;
  } sobel_result_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sobel_pkg::CFG_DAT_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [sobel_pkg::PIX_W-1:0]     pixel;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [sobel_pkg::PIX_W-1:0]     gradient;
  logic                            frame_last;

  sobel_horizontal_gradient dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .gradient   (gradient),
    .frame_last (frame_last)
  );

  // gradient predictor state
  logic [sobel_pkg::WIDTH_W-1:0]  width_reg;
  logic [sobel_pkg::HEIGHT_W-1:0] height_reg;
  logic [sobel_pkg::PIX_W-1:0]    row_above [sobel_pkg::MAX_WIDTH];
  logic [sobel_pkg::PIX_W-1:0]    row_two_above [sobel_pkg::MAX_WIDTH];
  logic [sobel_pkg::PIX_W-1:0]    win [9];
  int unsigned                    col_pos;
  int unsigned                    row_pos;

  sobel_result_t expected_gradients[$];
  int            errors;
  int            pixels_sent;
  int            idle_pct;
  int            stall_pct;
  int            stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_length(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int unsigned active_width();
    if (width_reg < sobel_pkg::WIDTH_MIN) return sobel_pkg::WIDTH_MIN;
    if (width_reg > sobel_pkg::WIDTH_MAX) return sobel_pkg::WIDTH_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg < sobel_pkg::HEIGHT_MIN) return sobel_pkg::HEIGHT_MIN;
    return height_reg;
  endfunction

  function automatic void predict_gradient(input logic [sobel_pkg::PIX_W-1:0] p);
    int unsigned                 w;
    int unsigned                 h;
    logic [sobel_pkg::PIX_W-1:0] up1;
    logic [sobel_pkg::PIX_W-1:0] up2;
    int                          g;
    sobel_result_t               res;
    w = active_width();
    h = active_height();
    up2 = row_two_above[col_pos];
    up1 = row_above[col_pos];
    row_two_above[col_pos] = up1;
    row_above[col_pos] = p;
    for (int i = 0; i < 3; i++) begin
      win[i*3]     = win[i*3 + 1];
      win[i*3 + 1] = win[i*3 + 2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = p;
    if (row_pos >= 2 && col_pos >= 2) begin
      g = (int'(win[2]) - int'(win[0])) + 2 * (int'(win[5]) - int'(win[3]))
        + (int'(win[8]) - int'(win[6]));
      if (g < 0) g = -g;
      if (g > 255) g = 255;
      res.gradient   = sobel_pkg::PIX_W'(g);
      res.frame_last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
      expected_gradients.push_back(res);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic logic [sobel_pkg::PIX_W-1:0] next_pixel(input fill_t fill);
    case (fill)
      FILL_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      FILL_SMOOTH:  return sobel_pkg::PIX_W'(col_pos * 37 + $urandom_range(0, 7));
      default:      return sobel_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [sobel_pkg::PIX_W-1:0] p);
    int gap;
    gap = gap_length(idle_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel = p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_gradient(p);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int n, input fill_t fill);
    for (int i = 0; i < n; i++) send_pixel(next_pixel(fill));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_gradients.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sobel_pkg::CFG_DAT_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == sobel_pkg::REG_IMAGE_WIDTH) begin
      width_reg = data[sobel_pkg::WIDTH_W-1:0];
      col_pos = 0;
      row_pos = 0;
    end else if (idx == sobel_pkg::REG_IMAGE_HEIGHT) begin
      height_reg = data[sobel_pkg::HEIGHT_W-1:0];
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, sobel_pkg::CFG_DAT_W'(w));
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, sobel_pkg::CFG_DAT_W'(h));
  endtask

  // frame size after reset, no register written yet: first row gives no result
  task automatic test_reset_size();
    idle_pct = 20;
    stall_pct = 20;
    send_pixels(SHORT_RUN, FILL_RANDOM);
  endtask

  // two 4x3 frames back to back: exact 255, small values, negative saturation
  task automatic test_directed_frames();
    logic [sobel_pkg::PIX_W-1:0] frame_a [12];
    logic [sobel_pkg::PIX_W-1:0] frame_b [12];
    frame_a = '{8'd0, 8'd9, 8'd255, 8'd0,
                8'd0, 8'd9, 8'd0,   8'd9,
                8'd0, 8'd9, 8'd0,   8'd9};
    frame_b = '{8'd255, 8'd1, 8'd0, 8'd2,
                8'd255, 8'd0, 8'd0, 8'd0,
                8'd255, 8'd7, 8'd0, 8'd0};
    idle_pct = 0;
    stall_pct = 0;
    set_size(4, 3);
    foreach (frame_a[i]) send_pixel(frame_a[i]);
    foreach (frame_b[i]) send_pixel(frame_b[i]);
  endtask

  // sizes below the minimum, above the maximum, and masked upper data bits
  task automatic test_size_clamps();
    idle_pct = 30;
    stall_pct = 30;
    set_size(0, 0);
    send_pixels(18, FILL_EXTREME);
    set_size(2, 2);
    send_pixels(9, FILL_RANDOM);
    set_size(12'h803, 4095);
    send_pixels(15, FILL_RANDOM);
    idle_pct = 10;
    stall_pct = 10;
    set_size(2047, 3);
    send_pixels(SHORT_RUN, FILL_SMOOTH);
  endtask

  // writes to unused indexes must not restart the frame
  task automatic test_spare_index();
    idle_pct = 20;
    stall_pct = 40;
    set_size(5, 4);
    send_pixels(8, FILL_RANDOM);
    write_reg(REG_SPARE_A, 12'hFFF);
    write_reg(REG_SPARE_B, 12'h003);
    send_pixels(12, FILL_RANDOM);
  endtask

  // a register write in the middle of a frame starts a new one
  task automatic test_restart_mid_frame();
    set_size(6, 5);
    send_pixels(20, FILL_RANDOM);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 12'd5);
    send_pixels(30, FILL_EXTREME);
  endtask

  task automatic test_random_frames();
    int    stop_at;
    int    w;
    int    h;
    int    n;
    fill_t fill;
    stop_at = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < stop_at) begin
      idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      if ($urandom_range(0, 99) < 70) begin
        w = ($urandom_range(0, 9) < 8) ? $urandom_range(3, 12) : $urandom_range(13, 64);
        h = $urandom_range(3, 6);
        if (w == 3) w = $urandom_range(0, 3);
        if (h == 3) h = $urandom_range(0, 3);
        set_size(w, h);
      end
      case ($urandom_range(0, 2))
        0:       fill = FILL_EXTREME;
        1:       fill = FILL_SMOOTH;
        default: fill = FILL_RANDOM;
      endcase
      n = active_width() * active_height();
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n - 1);
      send_pixels(n, fill);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) stall_left = gap_length(stall_pct);
    out_stall = (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    sobel_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_gradients.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual gradient %0d frame_last %0d",
                 $time, gradient, frame_last);
        errors++;
      end else begin
        want = expected_gradients.pop_front();
        if (gradient !== want.gradient) begin
          $display("%0t: gradient mismatch, expected %0d, actual %0d",
                   $time, want.gradient, gradient);
          errors++;
        end
        if (frame_last !== want.frame_last) begin
          $display("%0t: frame_last mismatch, expected %0d, actual %0d",
                   $time, want.frame_last, frame_last);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = sobel_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel = '0;
    errors = 0;
    pixels_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    width_reg = sobel_pkg::WIDTH_RESET;
    height_reg = sobel_pkg::HEIGHT_RESET;
    foreach (row_above[i]) row_above[i] = '0;
    foreach (row_two_above[i]) row_two_above[i] = '0;
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_size();
    test_directed_frames();
    test_size_clamps();
    test_spare_index();
    test_restart_mid_frame();
    test_random_frames();

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_gradients.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/sobel_pkg.sv
rtl/sobel_line_buf.sv
rtl/sobel_horizontal_gradient.sv
dv/testbench.sv
